FILE: rtl/bqms_pkg.sv
package bqms_pkg;

    localparam int DEF_SAMPLE_WIDTH = 24;
    localparam int DEF_COEF_WIDTH   = 24;

    // Internal values, delays and the accumulator
    localparam int INT_W = 40;
    localparam int ACC_W = 48;

    localparam int PC_W      = 5;
    localparam int CFG_IDX_W = 3;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_MODE   = 3'd0,
        REG_FF0    = 3'd1,
        REG_FF1    = 3'd2,
        REG_FF2    = 3'd3,
        REG_FB1    = 3'd4,
        REG_FB2    = 3'd5
    } cfg_reg_t;

    typedef enum logic [1:0] {
        MODE_DF1  = 2'd0,
        MODE_TDF1 = 2'd1,
        MODE_DF2  = 2'd2,
        MODE_TDF2 = 2'd3
    } mode_t;

    // Multiplier operand
    typedef enum logic [2:0] {
        OP_X, OP_X1, OP_X2, OP_Y1, OP_Y2, OP_W, OP_Y
    } opnd_t;

    // Coefficient operand
    typedef enum logic [2:0] {
        C_A0, C_A1, C_A2, C_B1, C_B2
    } coef_sel_t;

    // Accumulator base: keep the running sum or load a fresh start value
    typedef enum logic [2:0] {
        B_ACC, B_ZERO, B_X, B_X1, B_X2, B_Y1, B_Y2
    } base_t;

    // Term added to (or subtracted from) the base
    typedef enum logic [1:0] {
        T_NONE, T_PROD, T_X1
    } term_t;

    // Where the saturated accumulator result goes
    typedef enum logic [3:0] {
        D_NONE, D_W, D_X1, D_X2, D_Y1, D_Y2, D_Y, D_SHIFT_ALL, D_SHIFT_W
    } dst_t;

    typedef enum logic [1:0] {
        SEQ_NEXT, SEQ_DISPATCH, SEQ_END
    } seq_t;

    typedef struct packed {
        opnd_t     msrc;
        coef_sel_t mcoef;
        base_t     base;
        term_t     term;
        logic      sub;
        dst_t      dst;
        seq_t      seq;
    } ucode_t;

    localparam logic [PC_W-1:0] ENTRY_DF1  = 5'd1;
    localparam logic [PC_W-1:0] ENTRY_TDF1 = 5'd8;
    localparam logic [PC_W-1:0] ENTRY_DF2  = 5'd15;
    localparam logic [PC_W-1:0] ENTRY_TDF2 = 5'd22;

    function automatic logic [PC_W-1:0] mode_entry(input mode_t m);
        logic [PC_W-1:0] e;
        unique case (m)
            MODE_DF1:  e = ENTRY_DF1;
            MODE_TDF1: e = ENTRY_TDF1;
            MODE_DF2:  e = ENTRY_DF2;
            MODE_TDF2: e = ENTRY_TDF2;
        endcase
        return e;
    endfunction

    function automatic ucode_t uw(input opnd_t msrc, input coef_sel_t mcoef,
                                  input base_t base, input term_t term,
                                  input logic sub, input dst_t dst,
                                  input seq_t seq);
        ucode_t w;
        w.msrc  = msrc;
        w.mcoef = mcoef;
        w.base  = base;
        w.term  = term;
        w.sub   = sub;
        w.dst   = dst;
        w.seq   = seq;
        return w;
    endfunction

    // Microprogram. A product issued in one step is summed in the next.
    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] addr);
        ucode_t w;
        case (addr)
            5'd0:  w = uw(OP_X,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_DISPATCH);
            // direct form I
            5'd1:  w = uw(OP_X,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_NEXT);
            5'd2:  w = uw(OP_X1, C_A1, B_ZERO, T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd3:  w = uw(OP_X2, C_A2, B_ACC,  T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd4:  w = uw(OP_Y1, C_B1, B_ACC,  T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd5:  w = uw(OP_Y2, C_B2, B_ACC,  T_PROD, 1'b1, D_NONE,      SEQ_NEXT);
            5'd6:  w = uw(OP_X,  C_A0, B_ACC,  T_PROD, 1'b1, D_SHIFT_ALL, SEQ_NEXT);
            5'd7:  w = uw(OP_X,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_END);
            // transposed direct form I
            5'd8:  w = uw(OP_X,  C_A0, B_X,    T_X1,   1'b0, D_W,         SEQ_NEXT);
            5'd9:  w = uw(OP_W,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_NEXT);
            5'd10: w = uw(OP_W,  C_B1, B_Y1,   T_PROD, 1'b0, D_Y,         SEQ_NEXT);
            5'd11: w = uw(OP_W,  C_B2, B_X2,   T_PROD, 1'b1, D_X1,        SEQ_NEXT);
            5'd12: w = uw(OP_W,  C_A1, B_ZERO, T_PROD, 1'b1, D_X2,        SEQ_NEXT);
            5'd13: w = uw(OP_W,  C_A2, B_Y2,   T_PROD, 1'b0, D_Y1,        SEQ_NEXT);
            5'd14: w = uw(OP_W,  C_A0, B_ZERO, T_PROD, 1'b0, D_Y2,        SEQ_END);
            // canonical direct form II
            5'd15: w = uw(OP_X1, C_B1, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_NEXT);
            5'd16: w = uw(OP_X2, C_B2, B_X,    T_PROD, 1'b1, D_NONE,      SEQ_NEXT);
            5'd17: w = uw(OP_X1, C_A1, B_ACC,  T_PROD, 1'b1, D_W,         SEQ_NEXT);
            5'd18: w = uw(OP_X2, C_A2, B_ZERO, T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd19: w = uw(OP_W,  C_A0, B_ACC,  T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd20: w = uw(OP_W,  C_A0, B_ACC,  T_PROD, 1'b0, D_SHIFT_W,   SEQ_NEXT);
            5'd21: w = uw(OP_W,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_END);
            // transposed direct form II
            5'd22: w = uw(OP_X,  C_A0, B_ACC,  T_NONE, 1'b0, D_NONE,      SEQ_NEXT);
            5'd23: w = uw(OP_X,  C_A1, B_X1,   T_PROD, 1'b0, D_Y,         SEQ_NEXT);
            5'd24: w = uw(OP_Y,  C_B1, B_X2,   T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd25: w = uw(OP_X,  C_A2, B_ACC,  T_PROD, 1'b1, D_X1,        SEQ_NEXT);
            5'd26: w = uw(OP_Y,  C_B2, B_ZERO, T_PROD, 1'b0, D_NONE,      SEQ_NEXT);
            5'd27: w = uw(OP_X,  C_A0, B_ACC,  T_PROD, 1'b1, D_X2,        SEQ_END);
            default: w = uw(OP_X, C_A0, B_ACC, T_NONE, 1'b0, D_NONE,      SEQ_END);
        endcase
        return w;
    endfunction

    // Clamp the accumulator into the internal 40-bit range
    function automatic logic signed [INT_W-1:0] sat_int(input logic signed [ACC_W-1:0] v);
        logic signed [ACC_W-1:0] hi;
        logic signed [ACC_W-1:0] lo;
        logic signed [INT_W-1:0] r;
        hi = {{(ACC_W-INT_W+1){1'b0}}, {(INT_W-1){1'b1}}};
        lo = {{(ACC_W-INT_W+1){1'b1}}, {(INT_W-1){1'b0}}};
        if (v > hi) begin
            r = hi[INT_W-1:0];
        end else if (v < lo) begin
            r = lo[INT_W-1:0];
        end else begin
            r = v[INT_W-1:0];
        end
        return r;
    endfunction

endpackage

FILE: rtl/biquad_filter_multi_structure.sv
// The microprogram runs one product per cycle through a single shared multiplier, plus one
// dispatch step; the final step is held while the previous result still waits.
// s_ready drops while the microprogram runs; a waiting result does not block the next input.
// Reset (aresetn low, synchronous): direct form I, a0 = 1.0, other coefficients and all
// delays zero, no result pending.
module biquad_filter_multi_structure
    import bqms_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DEF_SAMPLE_WIDTH,
    parameter int COEF_WIDTH   = DEF_COEF_WIDTH
) (
    input  logic                          aclk,
    input  logic                          aresetn,

    input  logic                          cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]          cfg_index,
    input  logic [COEF_WIDTH-1:0]         cfg_data,

    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic signed [SAMPLE_WIDTH-1:0] s_sample_in,

    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [SAMPLE_WIDTH-1:0] m_sample_out
);

    localparam int FRAC   = COEF_WIDTH - 4;
    localparam int PROD_W = INT_W + COEF_WIDTH;
    localparam int Q_W    = PROD_W - FRAC;

    // Configuration
    mode_t                        mode_reg;
    logic signed [COEF_WIDTH-1:0] ff0_reg, ff1_reg, ff2_reg, fb1_reg, fb2_reg;

    // Sequencer
    logic            busy_reg;
    logic [PC_W-1:0] pc_reg;
    ucode_t          uc;
    logic            step_go;
    logic            end_go;

    // Datapath
    logic signed [INT_W-1:0]  x_reg, w_reg, y_reg;
    logic signed [INT_W-1:0]  x1_reg, x2_reg, y1_reg, y2_reg;
    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  acc_next;

    logic signed [INT_W-1:0]      mul_a;
    logic signed [COEF_WIDTH-1:0] mul_c;
    logic signed [ACC_W-1:0]      base_val;
    logic signed [ACC_W-1:0]      term_val;
    logic signed [Q_W-1:0]        prod_q;
    logic signed [INT_W-1:0]      res_sat;

    logic                          m_valid_reg;
    logic signed [SAMPLE_WIDTH-1:0] m_sample_out_reg;
    logic signed [SAMPLE_WIDTH-1:0] out_sat;

    assign s_ready      = ~busy_reg;
    assign m_valid      = m_valid_reg;
    assign m_sample_out = m_sample_out_reg;

    assign uc      = ucode_rom(pc_reg);
    // Hold the final step while the previous result still waits
    assign step_go = busy_reg && !(uc.seq == SEQ_END && m_valid_reg && !m_ready);
    assign end_go  = step_go && (uc.seq == SEQ_END);

    always_comb begin
        unique case (uc.msrc)
            OP_X:    mul_a = x_reg;
            OP_X1:   mul_a = x1_reg;
            OP_X2:   mul_a = x2_reg;
            OP_Y1:   mul_a = y1_reg;
            OP_Y2:   mul_a = y2_reg;
            OP_W:    mul_a = w_reg;
            OP_Y:    mul_a = y_reg;
            default: mul_a = x_reg;
        endcase
        unique case (uc.mcoef)
            C_A0:    mul_c = ff0_reg;
            C_A1:    mul_c = ff1_reg;
            C_A2:    mul_c = ff2_reg;
            C_B1:    mul_c = fb1_reg;
            C_B2:    mul_c = fb2_reg;
            default: mul_c = ff0_reg;
        endcase
    end

    // Round half up: drop FRAC bits, add the highest dropped bit back in
    assign prod_q = prod_reg[PROD_W-1:FRAC];

    always_comb begin
        unique case (uc.base)
            B_ACC:   base_val = acc_reg;
            B_ZERO:  base_val = '0;
            B_X:     base_val = ACC_W'(x_reg);
            B_X1:    base_val = ACC_W'(x1_reg);
            B_X2:    base_val = ACC_W'(x2_reg);
            B_Y1:    base_val = ACC_W'(y1_reg);
            B_Y2:    base_val = ACC_W'(y2_reg);
            default: base_val = acc_reg;
        endcase
        unique case (uc.term)
            T_NONE:  term_val = '0;
            T_PROD:  term_val = ACC_W'(prod_q) + ACC_W'({1'b0, prod_reg[FRAC-1]});
            T_X1:    term_val = ACC_W'(x1_reg);
            default: term_val = '0;
        endcase
        acc_next = uc.sub ? (base_val - term_val) : (base_val + term_val);
    end

    assign res_sat = sat_int(acc_next);

    always_comb begin
        logic signed [INT_W-1:0] smax;
        logic signed [INT_W-1:0] smin;
        smax = {{(INT_W-SAMPLE_WIDTH+1){1'b0}}, {(SAMPLE_WIDTH-1){1'b1}}};
        smin = {{(INT_W-SAMPLE_WIDTH+1){1'b1}}, {(SAMPLE_WIDTH-1){1'b0}}};
        if (y_reg > smax) begin
            out_sat = smax[SAMPLE_WIDTH-1:0];
        end else if (y_reg < smin) begin
            out_sat = smin[SAMPLE_WIDTH-1:0];
        end else begin
            out_sat = y_reg[SAMPLE_WIDTH-1:0];
        end
    end

    // Configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg <= MODE_DF1;
            ff0_reg  <= COEF_WIDTH'(1) << FRAC;
            ff1_reg  <= '0;
            ff2_reg  <= '0;
            fb1_reg  <= '0;
            fb2_reg  <= '0;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_MODE: mode_reg <= mode_t'(cfg_data[1:0]);
                REG_FF0:  ff0_reg  <= cfg_data;
                REG_FF1:  ff1_reg  <= cfg_data;
                REG_FF2:  ff2_reg  <= cfg_data;
                REG_FB1:  fb1_reg  <= cfg_data;
                REG_FB2:  fb2_reg  <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sequencer and output beat
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg    <= 1'b0;
            pc_reg      <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (!busy_reg && s_valid) begin
                busy_reg <= 1'b1;
                pc_reg   <= '0;
            end else if (step_go) begin
                unique case (uc.seq)
                    SEQ_NEXT:     pc_reg   <= pc_reg + 1'b1;
                    SEQ_DISPATCH: pc_reg   <= mode_entry(mode_reg);
                    SEQ_END:      busy_reg <= 1'b0;
                endcase
            end
            if (end_go) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (end_go) begin
            m_sample_out_reg <= out_sat;
        end
    end

    // Delay line state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x1_reg <= '0;
            x2_reg <= '0;
            y1_reg <= '0;
            y2_reg <= '0;
        end else if (step_go) begin
            unique case (uc.dst)
                D_X1: x1_reg <= res_sat;
                D_X2: x2_reg <= res_sat;
                D_Y1: y1_reg <= res_sat;
                D_Y2: y2_reg <= res_sat;
                D_SHIFT_ALL: begin
                    x2_reg <= x1_reg;
                    x1_reg <= x_reg;
                    y2_reg <= y1_reg;
                    y1_reg <= res_sat;
                end
                D_SHIFT_W: begin
                    x2_reg <= x1_reg;
                    x1_reg <= w_reg;
                end
                default: ;
            endcase
        end
    end

    // Working registers
    always_ff @(posedge aclk) begin
        if (!busy_reg && s_valid) begin
            x_reg <= INT_W'(s_sample_in);
        end
        if (step_go) begin
            prod_reg <= mul_a * mul_c;
            acc_reg  <= acc_next;
            if (uc.dst == D_W) begin
                w_reg <= res_sat;
            end
            if (uc.dst == D_Y || uc.dst == D_SHIFT_ALL || uc.dst == D_SHIFT_W) begin
                y_reg <= res_sat;
            end
        end
    end

endmodule
